>>> src/codon_mutation_filter_assert.svh
// ----------------------------------------------------------------------------
// Codon mutation filter assertion macros
// Short forms for the concurrent checks used in the filter's RTL. Each macro
// expects clk and rst_n in scope and disables its check while reset is held.
// ----------------------------------------------------------------------------
`ifndef CODON_MUTATION_FILTER_ASSERT_SVH
`define CODON_MUTATION_FILTER_ASSERT_SVH

// Same-cycle implication
`define CMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cmf_pkg.sv
// ----------------------------------------------------------------------------
// Codon mutation filter package
// Verdict codes, register indexes, reset values and the result record shared
// between the top level and the per-read tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cmf_pkg;

  // Verdict codes, in priority order after KEPT
  typedef enum logic [1:0] {
    VERDICT_KEPT      = 2'd0,
    VERDICT_LOW_QUAL  = 2'd1,
    VERDICT_TOO_MANY  = 2'd2,
    VERDICT_FORBIDDEN = 2'd3
  } verdict_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_QUALITY_MIN  = 2'd0;
  localparam logic [1:0] CFG_MAX_CODONS   = 2'd1;
  localparam logic [1:0] CFG_FORBID_MASK  = 2'd2;

  // Register reset values
  localparam logic [6:0]  QUALITY_MIN_RST = 7'd0;
  localparam logic [6:0]  MAX_CODONS_RST  = 7'd1;
  localparam logic [63:0] FORBID_MASK_RST = 64'h9999_9999_9999_9999;

  // Mutated codon count saturates here
  localparam logic [6:0]  COUNT_SAT       = 7'd127;

  // Last phase of a codon (three bases per codon)
  localparam logic [1:0]  PHASE_LAST      = 2'd2;

  // Verdict of one read as it leaves the tracker
  typedef struct packed {
    verdict_t   verdict;
    logic [6:0] codon_count;
  } read_result_t;

endpackage

`default_nettype wire

>>> src/cmf_read_tracker.sv
// ----------------------------------------------------------------------------
// Codon mutation filter - per-read tracker
// Holds the codon and read state, folds in one base per step and forms the
// read's verdict at its last base.
// ----------------------------------------------------------------------------
`default_nettype none

module cmf_read_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            read_base,
  input  wire logic [7:0]            reference_base,
  input  wire logic [6:0]            base_quality,
  input  wire logic                  last_base,
  input  wire logic [6:0]            quality_min,
  input  wire logic [6:0]            max_codons,
  input  wire logic [63:0]           forbid_mask,
  output cmf_pkg::read_result_t      result
);

  // Codon state
  logic [1:0] phase_r;
  logic [5:0] letters_r;
  logic       all_acgt_r;
  logic       codon_mism_r;
  // Read state
  logic [6:0] count_r;
  logic       low_qual_r;
  logic       forbid_r;

  logic [1:0] phase_c;
  logic       is_acgt;
  logic [1:0] code;
  logic [5:0] letters_upd;
  logic       all_acgt_upd;
  logic       mismatch;
  logic       low_qual_hit;
  logic       new_mut;
  logic       codon_mism_upd;
  logic [6:0] count_upd;
  logic       low_qual_upd;
  logic       codon_end;
  logic       forbid_upd;

  // Letter decode: A C G T only, upper case
  always_comb begin
    is_acgt = 1'b1;
    code    = 2'd0;
    unique case (read_base)
      8'h41:   code = 2'd0;
      8'h43:   code = 2'd1;
      8'h47:   code = 2'd2;
      8'h54:   code = 2'd3;
      default: is_acgt = 1'b0;
    endcase
  end

  // Codon letters packed first letter high
  always_comb begin
    phase_c     = (phase_r > cmf_pkg::PHASE_LAST) ? cmf_pkg::PHASE_LAST : phase_r;
    letters_upd = letters_r;
    if (is_acgt) begin
      unique case (phase_c)
        2'd0:    letters_upd = letters_r | {code, 4'd0};
        2'd1:    letters_upd = letters_r | {2'd0, code, 2'd0};
        default: letters_upd = letters_r | {4'd0, code};
      endcase
    end
    all_acgt_upd = all_acgt_r & is_acgt;
  end

  // Mismatch, low-quality and count update
  always_comb begin
    mismatch       = (read_base != reference_base) && !low_qual_r;
    low_qual_hit   = mismatch && (base_quality < quality_min);
    new_mut        = mismatch && !low_qual_hit && !codon_mism_r;
    codon_mism_upd = codon_mism_r | new_mut;
    count_upd      = (new_mut && (count_r != cmf_pkg::COUNT_SAT)) ? count_r + 7'd1 : count_r;
    low_qual_upd   = low_qual_r | low_qual_hit;
    codon_end      = (phase_c == cmf_pkg::PHASE_LAST);
    forbid_upd     = forbid_r |
                     (codon_end && all_acgt_upd && codon_mism_upd && forbid_mask[letters_upd]);
  end

  // Verdict by priority
  always_comb begin
    priority if (low_qual_upd) begin
      result.verdict = cmf_pkg::VERDICT_LOW_QUAL;
    end else if (count_upd > max_codons) begin
      result.verdict = cmf_pkg::VERDICT_TOO_MANY;
    end else if (forbid_upd) begin
      result.verdict = cmf_pkg::VERDICT_FORBIDDEN;
    end else begin
      result.verdict = cmf_pkg::VERDICT_KEPT;
    end
    result.codon_count = count_upd;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 2'd0;
      letters_r    <= 6'd0;
      all_acgt_r   <= 1'b1;
      codon_mism_r <= 1'b0;
      count_r      <= 7'd0;
      low_qual_r   <= 1'b0;
      forbid_r     <= 1'b0;
    end else if (step) begin
      if (last_base) begin
        phase_r      <= 2'd0;
        letters_r    <= 6'd0;
        all_acgt_r   <= 1'b1;
        codon_mism_r <= 1'b0;
        count_r      <= 7'd0;
        low_qual_r   <= 1'b0;
        forbid_r     <= 1'b0;
      end else begin
        count_r    <= count_upd;
        low_qual_r <= low_qual_upd;
        forbid_r   <= forbid_upd;
        if (codon_end) begin
          phase_r      <= 2'd0;
          letters_r    <= 6'd0;
          all_acgt_r   <= 1'b1;
          codon_mism_r <= 1'b0;
        end else begin
          phase_r      <= phase_c + 2'd1;
          letters_r    <= letters_upd;
          all_acgt_r   <= all_acgt_upd;
          codon_mism_r <= codon_mism_upd;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/codon_mutation_filter.sv
// ----------------------------------------------------------------------------
// Codon mutation filter - top level
// Streams read bases against the reference and gives one verdict per read.
// ----------------------------------------------------------------------------
// One base is taken per cycle unless a last base is stalled. A base lands
// in an input register; when it leaves that register the read tracker folds
// it into the codon and read state, and a last base loads the result
// register at that same edge, which raises its verdict. A base that is not
// last never waits in the input register; only a last base held behind an
// untaken verdict stalls it, and with it the input, so in_ready follows
// out_ready combinationally in that case. Registers should be written only
// with both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module codon_mutation_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Base input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_read_base,
  input  wire logic [7:0]  in_reference_base,
  input  wire logic [6:0]  in_base_quality,
  input  wire logic        in_last_base,
  // Verdict output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_verdict,
  output logic [6:0]       out_mutated_codon_count,
  output logic [31:0]      out_low_quality_rejects,
  output logic [31:0]      out_too_many_rejects,
  output logic [31:0]      out_forbidden_rejects,
  // Register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // Configuration registers
  logic [6:0]  quality_min_r;
  logic [6:0]  max_codons_r;
  logic [63:0] forbid_mask_r;

  // Input stage
  logic        s1_valid_r;
  logic [7:0]  s1_read_r;
  logic [7:0]  s1_ref_r;
  logic [6:0]  s1_qual_r;
  logic        s1_last_r;
  logic        s1_fire;
  logic        fire_last;

  // Output stage and running totals
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  out_verdict_r;
  logic [6:0]  out_count_r;
  logic [31:0] low_qual_tot_r;
  logic [31:0] too_many_tot_r;
  logic [31:0] forbid_tot_r;

  cmf_pkg::read_result_t result;

  // Config port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_min_r <= cmf_pkg::QUALITY_MIN_RST;
      max_codons_r  <= cmf_pkg::MAX_CODONS_RST;
      forbid_mask_r <= cmf_pkg::FORBID_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cmf_pkg::CFG_QUALITY_MIN: quality_min_r <= cfg_data[6:0];
        cmf_pkg::CFG_MAX_CODONS:  max_codons_r  <= cfg_data[6:0];
        cmf_pkg::CFG_FORBID_MASK: forbid_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: only a last base needs room in the output register
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign fire_last = s1_fire && s1_last_r;
  assign in_ready  = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_read_r <= in_read_base;
      s1_ref_r  <= in_reference_base;
      s1_qual_r <= in_base_quality;
      s1_last_r <= in_last_base;
    end
  end

  // Per-read codon tracking
  cmf_read_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_fire),
    .read_base      (s1_read_r),
    .reference_base (s1_ref_r),
    .base_quality   (s1_qual_r),
    .last_base      (s1_last_r),
    .quality_min    (quality_min_r),
    .max_codons     (max_codons_r),
    .forbid_mask    (forbid_mask_r),
    .result         (result)
  );

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      low_qual_tot_r <= 32'd0;
      too_many_tot_r <= 32'd0;
      forbid_tot_r   <= 32'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire_last) begin
        unique case (result.verdict)
          cmf_pkg::VERDICT_LOW_QUAL:  low_qual_tot_r <= low_qual_tot_r + 32'd1;
          cmf_pkg::VERDICT_TOO_MANY:  too_many_tot_r <= too_many_tot_r + 32'd1;
          cmf_pkg::VERDICT_FORBIDDEN: forbid_tot_r   <= forbid_tot_r + 32'd1;
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire_last) begin
      out_verdict_r <= result.verdict;
      out_count_r   <= result.codon_count;
    end
  end

  // Totals only move with a new verdict, so they serve as payload directly
  assign out_valid               = out_valid_r;
  assign out_verdict             = out_verdict_r;
  assign out_mutated_codon_count = out_count_r;
  assign out_low_quality_rejects = low_qual_tot_r;
  assign out_too_many_rejects    = too_many_tot_r;
  assign out_forbidden_rejects   = forbid_tot_r;

  // Checks
  `include "codon_mutation_filter_assert.svh"

  `CMF_ASSERT_NOW(a_too_many_count,
    out_valid_r && (out_verdict_r == cmf_pkg::VERDICT_TOO_MANY),
    out_count_r > max_codons_r, "too-many verdict with count within limit")
  `CMF_ASSERT_NOW(a_kept_count,
    out_valid_r && (out_verdict_r == cmf_pkg::VERDICT_KEPT),
    out_count_r <= max_codons_r, "kept verdict with count over limit")
  `CMF_ASSERT_NEXT(a_low_qual_total,
    fire_last && (result.verdict == cmf_pkg::VERDICT_LOW_QUAL),
    low_qual_tot_r == $past(low_qual_tot_r) + 32'd1, "low-quality total did not step")
  `CMF_ASSERT_NEXT(a_totals_hold, !fire_last,
    $stable(too_many_tot_r) && $stable(forbid_tot_r), "totals moved without a verdict")
  `CMF_ASSERT_NOW(a_nonlast_flows, s1_valid_r && !s1_last_r,
    s1_fire && in_ready, "non-last base stalled")

endmodule

`default_nettype wire

>>> bench/tb_codon_mutation_filter.sv
// ----------------------------------------------------------------------------
// Codon mutation filter testbench
// Streams reads into the filter one base per transaction. Idling and back
// pressure are random on both sides. A model of the per-read codon tracking
// inside the bench predicts each verdict and the running reject totals, and
// every verdict transaction is compared field by field against that model.
// ----------------------------------------------------------------------------
module tb_codon_mutation_filter;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it, writes there must be dropped
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned RANDOM_BASES = 30;
  localparam int unsigned LONG_BASES   = 384;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct {
    cmf_pkg::verdict_t verdict;
    logic [6:0]        codon_count;
    logic [31:0]       low_quality_total;
    logic [31:0]       too_many_total;
    logic [31:0]       forbidden_total;
  } verdict_rec_t;

  logic        clk                     = 1'b0;
  logic        rst_n                   = 1'b0;
  logic        in_valid                = 1'b0;
  logic        in_ready;
  logic [7:0]  in_read_base            = '0;
  logic [7:0]  in_reference_base       = '0;
  logic [6:0]  in_base_quality         = '0;
  logic        in_last_base            = 1'b0;
  logic        out_valid;
  logic        out_ready               = 1'b0;
  logic [1:0]  out_verdict;
  logic [6:0]  out_mutated_codon_count;
  logic [31:0] out_low_quality_rejects;
  logic [31:0] out_too_many_rejects;
  logic [31:0] out_forbidden_rejects;
  logic        cfg_valid               = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index               = '0;
  logic [63:0] cfg_data                = '0;

  // Register copies and per-read state of the verdict model
  logic [6:0]  quality_min_q    = cmf_pkg::QUALITY_MIN_RST;
  logic [6:0]  max_codons_q     = cmf_pkg::MAX_CODONS_RST;
  logic [63:0] forbid_mask_q    = cmf_pkg::FORBID_MASK_RST;
  logic [1:0]  phase_q          = '0;
  logic [5:0]  letters_q        = '0;
  logic        all_acgt_q       = 1'b1;
  logic        mismatched_q     = 1'b0;
  logic [6:0]  codon_count_q    = '0;
  logic        low_qual_seen_q  = 1'b0;
  logic        forbid_seen_q    = 1'b0;
  logic [31:0] low_qual_total_q = '0;
  logic [31:0] too_many_total_q = '0;
  logic [31:0] forbid_total_q   = '0;

  verdict_rec_t pending_verdicts[$];

  int unsigned error_count     = 0;
  int unsigned verdict_count   = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_off_cycles = 0;
  bit          tx_idle_en      = 1'b0;
  bit          rx_idle_en      = 1'b0;

  codon_mutation_filter i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_read_base            (in_read_base),
    .in_reference_base       (in_reference_base),
    .in_base_quality         (in_base_quality),
    .in_last_base            (in_last_base),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_verdict             (out_verdict),
    .out_mutated_codon_count (out_mutated_codon_count),
    .out_low_quality_rejects (out_low_quality_rejects),
    .out_too_many_rejects    (out_too_many_rejects),
    .out_forbidden_rejects   (out_forbidden_rejects),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("[%0t] verdict %0d: %s", $time, verdict_count, msg);
  endtask

  // Fold one accepted base into the model; a last base yields a verdict
  function automatic void track_base(input logic [7:0] rb, input logic [7:0] wb,
                                     input logic [6:0] qual, input logic last);
    logic [1:0]   phase;
    logic [1:0]   code;
    logic         is_acgt;
    verdict_rec_t rec;
    phase   = (phase_q > cmf_pkg::PHASE_LAST) ? cmf_pkg::PHASE_LAST : phase_q;
    is_acgt = 1'b1;
    code    = 2'd0;
    case (rb)
      "A":     code = 2'd0;
      "C":     code = 2'd1;
      "G":     code = 2'd2;
      "T":     code = 2'd3;
      default: is_acgt = 1'b0;
    endcase
    if (!is_acgt) all_acgt_q = 1'b0;
    else letters_q = letters_q | (6'(code) << (2 * (cmf_pkg::PHASE_LAST - phase)));

    // A low-quality mismatch freezes the codon count for the rest of the read
    if (rb != wb && !low_qual_seen_q) begin
      if (qual < quality_min_q) begin
        low_qual_seen_q = 1'b1;
      end else if (!mismatched_q) begin
        mismatched_q = 1'b1;
        if (codon_count_q != cmf_pkg::COUNT_SAT) codon_count_q++;
      end
    end

    // Codon closes on its third base or at the read end; partial ones never forbid
    if (phase == cmf_pkg::PHASE_LAST || last) begin
      if (phase == cmf_pkg::PHASE_LAST && all_acgt_q && mismatched_q &&
          forbid_mask_q[letters_q])
        forbid_seen_q = 1'b1;
      phase_q      = '0;
      letters_q    = '0;
      all_acgt_q   = 1'b1;
      mismatched_q = 1'b0;
    end else begin
      phase_q = phase + 2'd1;
    end

    if (last) begin
      rec.codon_count = codon_count_q;
      if (low_qual_seen_q) begin
        rec.verdict = cmf_pkg::VERDICT_LOW_QUAL;
        low_qual_total_q++;
      end else if (codon_count_q > max_codons_q) begin
        rec.verdict = cmf_pkg::VERDICT_TOO_MANY;
        too_many_total_q++;
      end else if (forbid_seen_q) begin
        rec.verdict = cmf_pkg::VERDICT_FORBIDDEN;
        forbid_total_q++;
      end else begin
        rec.verdict = cmf_pkg::VERDICT_KEPT;
      end
      rec.low_quality_total = low_qual_total_q;
      rec.too_many_total    = too_many_total_q;
      rec.forbidden_total   = forbid_total_q;
      pending_verdicts = {pending_verdicts, rec};
      codon_count_q   = '0;
      low_qual_seen_q = 1'b0;
      forbid_seen_q   = 1'b0;
    end
  endfunction

  // Watch all three channels: predict, check, apply writes, guard stalls
  always @(posedge clk) begin : monitor
    verdict_rec_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        verdict_count++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no read pending", out_verdict));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_verdict !== want.verdict)
            report_mismatch($sformatf("verdict got %0d, expected %0d",
                                      out_verdict, want.verdict));
          if (out_mutated_codon_count !== want.codon_count)
            report_mismatch($sformatf("codon count got %0d, expected %0d",
                                      out_mutated_codon_count, want.codon_count));
          if (out_low_quality_rejects !== want.low_quality_total)
            report_mismatch($sformatf("low-quality total got %0d, expected %0d",
                                      out_low_quality_rejects, want.low_quality_total));
          if (out_too_many_rejects !== want.too_many_total)
            report_mismatch($sformatf("too-many total got %0d, expected %0d",
                                      out_too_many_rejects, want.too_many_total));
          if (out_forbidden_rejects !== want.forbidden_total)
            report_mismatch($sformatf("forbidden total got %0d, expected %0d",
                                      out_forbidden_rejects, want.forbidden_total));
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        track_base(in_read_base, in_reference_base, in_base_quality, in_last_base);
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          cmf_pkg::CFG_QUALITY_MIN: quality_min_q = cfg_data[6:0];
          cmf_pkg::CFG_MAX_CODONS:  max_codons_q  = cfg_data[6:0];
          cmf_pkg::CFG_FORBID_MASK: forbid_mask_q = cfg_data;
          default: ;
        endcase
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** codon_mutation_filter: FAILED **");
        $finish;
      end
    end
  end

  // Verdict receiver: random stalls, plus a long hold-off on request
  initial begin : verdict_sink
    int unsigned n;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One base transaction; valid stays up when the next call follows at once
  task automatic send_base(input logic [7:0] rb, input logic [7:0] wb,
                           input logic [6:0] qual, input logic last);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_read_base      <= rb;
    in_reference_base <= wb;
    in_base_quality   <= qual;
    in_last_base      <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_seq(input string rd, input string rf, input logic [6:0] qual);
    for (int i = 0; i < rd.len(); i++)
      send_base(rd[i], rf[i], qual, i == rd.len() - 1);
  endtask

  // Mostly clean ACGT bases, some case flips, other letters and raw bytes
  task automatic send_random_read(input int unsigned len);
    logic [7:0]  acgt [4] = '{"A", "C", "G", "T"};
    logic [7:0]  rb;
    logic [7:0]  wb;
    logic [6:0]  qual;
    int unsigned r;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80)      rb = acgt[$urandom_range(0, 3)];
      else if (r < 88) rb = acgt[$urandom_range(0, 3)] | 8'h20;
      else if (r < 93) rb = "N";
      else             rb = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 85)      wb = rb;
      else if (r < 93) wb = acgt[$urandom_range(0, 3)];
      else if (r < 96) wb = rb ^ 8'h20;
      else             wb = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) != 0) qual = 7'($urandom_range(93, quality_min_q));
      else                           qual = 7'($urandom_range(0, 93));
      send_base(rb, wb, qual, i == len - 1);
    end
  endtask

  // Stop offering bases until every verdict is in and the pipe has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [6:0] qmin, input logic [6:0] max_codons,
                            input logic [63:0] mask);
    write_reg(cmf_pkg::CFG_QUALITY_MIN, {57'd0, qmin});
    write_reg(cmf_pkg::CFG_MAX_CODONS, {57'd0, max_codons});
    write_reg(cmf_pkg::CFG_FORBID_MASK, mask);
  endtask

  // Reset settings: each verdict path but low quality, field extremes
  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_seq("ACG", "ACG", 7'd40);
    send_seq("AAA", "AAC", 7'd40);           // mutated AAA, forbidden by reset mask
    send_seq("ACGTA", "ACGTT", 7'd93);       // mismatch in a partial codon
    send_seq("NAA", "NAC", 7'd0);            // other letter, counted, not forbidden
    send_seq("aaa", "AAA", 7'd40);           // case-only mismatch, lower case
    send_base(8'hFF, 8'h00, 7'd93, 1'b1);    // one-base read
    send_seq("ACGACG", "TCGTCG", 7'd20);     // two codons over a limit of one
  endtask

  // Quality threshold: below rejects and freezes the count, equal passes
  task automatic test_low_quality();
    write_reg(cmf_pkg::CFG_QUALITY_MIN, 64'd30);
    send_seq("ACGT", "ACGA", 7'd29);
    send_base("A", "C", 7'd10, 1'b0);
    send_base("C", "G", 7'd60, 1'b0);
    send_base("G", "G", 7'd60, 1'b0);
    send_base("T", "A", 7'd60, 1'b1);
    send_seq("AAA", "AAC", 7'd30);
    send_base("T", "A", 7'd50, 1'b0);
    send_base("T", "T", 7'd50, 1'b0);
    send_base("T", "T", 7'd50, 1'b0);
    send_base("G", "C", 7'd5, 1'b1);
    send_seq("GGG", "GGG", 7'd0);
  endtask

  // Register extremes and an ignored write, a few reads under each
  task automatic test_registers();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_config(7'd0, 7'd0, 64'd0);
        1: set_config(7'd93, 7'd86, '1);
        2: set_config(7'd0, 7'd86, cmf_pkg::FORBID_MASK_RST);
        3: set_config(7'd93, 7'd0, {$urandom(), $urandom()});
        default: set_config(7'($urandom_range(0, 40)), 7'($urandom_range(0, 5)),
                            {$urandom(), $urandom()});
      endcase
      write_reg(CFG_UNUSED, {$urandom(), $urandom()});
      for (int n = 0; n < 2; n++) send_random_read($urandom_range(1, 12));
    end
  endtask

  // Bulk random reads with settings changes and idling switched on and off
  task automatic test_random();
    int unsigned bases;
    int unsigned len;
    bases = 0;
    while (bases < RANDOM_BASES) begin
      if ($urandom_range(0, 19) == 0)
        set_config(($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 25)),
                   ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 4))
                                               : 7'($urandom_range(0, 86)),
                   {$urandom(), $urandom()});
      if ($urandom_range(0, 9) == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en = ($urandom_range(0, 2) != 0);
      end
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      send_random_read(len);
      bases += len;
    end
  endtask

  // Receiver holds off while short reads keep coming, so the input stalls
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_off_cycles = 300;
    for (int n = 0; n < 20; n++) send_random_read($urandom_range(1, 3));
    wait_idle();
  endtask

  // Every codon mutated past the saturation point of the count
  task automatic test_long_read();
    logic [7:0] acgt [4] = '{"A", "C", "G", "T"};
    int unsigned k;
    set_config(7'd0, 7'd86, '1);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int unsigned i = 0; i < LONG_BASES; i++) begin
      k = $urandom_range(0, 3);
      send_base(acgt[k], acgt[(k + 1) % 4], 7'd93, i == LONG_BASES - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_low_quality();
    test_registers();
    test_random();
    test_backpressure();
    test_long_read();
    wait_idle();
    if (error_count == 0) begin
      $display("** codon_mutation_filter: PASSED **");
    end else begin
      $display("** codon_mutation_filter: FAILED **");
    end
    $finish;
  end

endmodule
